[hw/rtl/lpm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the longest-prefix route lookup engine.
// No dependencies; used by every module of the block but lpm_ram.
package lpm_pkg;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 2;
  localparam int INDEX_W = 10;

  // Depth of the queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_HIT    = 2'd1,
    ST_MISS   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // One classified item as it waits in the queue.
  // key is the destination for a lookup and the prefix for a load.
  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  key;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  hop;
    logic [PORT_W-1:0]  port;
  } item_t;

  // One stored route.
  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  hop;
    logic [PORT_W-1:0]  port;
  } route_t;

endpackage

[hw/rtl/lpm_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/lpm_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input transfers, classifies them and queues them.
// Depends on lpm_pkg.
module lpm_front
  import lpm_pkg::*;
#(
  parameter int PORT_COUNT = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  output logic         item_valid,
  input  logic         item_ready,
  output item_t        item
);

  item_t             q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_CW-1:0]   q_cnt;
  item_t             cls;
  logic              push;
  logic              pop;
  logic [PORT_W-1:0] raw_port;

  // Classify: pick the key by operation, saturate the port.
  always_comb begin
    raw_port = s_axis_tdata[129:128];
    cls.op   = op_t'(s_axis_tuser[0]);
    cls.key  = (cls.op == OP_LOOKUP) ? s_axis_tdata[31:0] : s_axis_tdata[63:32];
    cls.mask = s_axis_tdata[95:64];
    cls.hop  = s_axis_tdata[127:96];
    cls.port = raw_port;
    if (32'(raw_port) >= 32'(PORT_COUNT)) begin
      cls.port = PORT_W'(PORT_COUNT - 1);
    end
  end

  assign s_axis_tready = (q_cnt != Q_CW'(Q_DEPTH));
  assign item_valid    = (q_cnt != '0);
  assign item          = q[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= Q_AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= Q_AW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        q_cnt <= Q_CW'(q_cnt + 1'b1);
      end else if (pop && !push) begin
        q_cnt <= Q_CW'(q_cnt - 1'b1);
      end
    end
  end

endmodule

[hw/rtl/lpm_back.sv]
`timescale 1ns / 1ps
// Back end: route table storage, linear longest-prefix scan, result register.
// Depends on lpm_pkg and lpm_ram.
module lpm_back
  import lpm_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    B_IDLE   = 3'b001,
    B_SCAN   = 3'b010,
    B_RESULT = 3'b100
  } bstate_t;

  bstate_t           state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     iss;
  logic              pend;
  logic [AW-1:0]     pidx;
  logic [ADDR_W-1:0] dest;
  logic              found;
  logic [AW-1:0]     best_idx;
  logic [ADDR_W-1:0] best_mask;
  logic [ADDR_W-1:0] best_hop;
  logic [PORT_W-1:0] best_port;

  status_t            res_status;
  logic [INDEX_W-1:0] res_idx;
  logic [ADDR_W-1:0]  res_hop;
  logic [PORT_W-1:0]  res_port;

  logic   out_free;
  logic   take;
  logic   full;
  logic   we;
  logic   rd_en;
  logic   res_set;
  route_t wr_route;
  route_t rd_route;
  logic   match;

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign item_ready = (state == B_IDLE) && out_free;
  assign take       = item_valid && item_ready;
  assign full       = (count == CW'(TABLE_DEPTH));
  assign we         = take && (item.op == OP_LOAD) && !full;
  assign rd_en      = (state == B_SCAN) && (iss != count);
  // A result enters the output register this cycle.
  assign res_set    = (take && ((item.op == OP_LOAD) || (count == '0))) ||
                      ((state == B_RESULT) && out_free);

  assign wr_route.prefix = item.key;
  assign wr_route.mask   = item.mask;
  assign wr_route.hop    = item.hop;
  assign wr_route.port   = item.port;

  lpm_ram #(
    .WIDTH ($bits(route_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (wr_route),
    .re    (rd_en),
    .raddr (iss[AW-1:0]),
    .rdata (rd_route)
  );

  // Equal masks replace the best so far: the later route wins.
  assign match = ((dest & rd_route.mask) == rd_route.prefix) &&
                 (!found || (rd_route.mask >= best_mask));

  assign m_axis_tuser = res_status;
  assign m_axis_tdata = {4'b0, res_port, res_hop, res_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      count         <= '0;
      iss           <= '0;
      pend          <= 1'b0;
      found         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (res_set) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      pend <= rd_en;
      pidx <= iss[AW-1:0];
      if (rd_en) begin
        iss <= CW'(iss + 1'b1);
      end
      unique case (state)
        B_IDLE: begin
          if (take) begin
            if (item.op == OP_LOAD) begin
              res_status    <= full ? ST_FULL : ST_LOADED;
              res_idx       <= '0;
              res_hop       <= '0;
              res_port      <= '0;
              if (!full) begin
                count <= CW'(count + 1'b1);
              end
            end else if (count == '0) begin
              res_status    <= ST_MISS;
              res_idx       <= '0;
              res_hop       <= '0;
              res_port      <= '0;
            end else begin
              dest  <= item.key;
              iss   <= '0;
              found <= 1'b0;
              state <= B_SCAN;
            end
          end
        end
        B_SCAN: begin
          if (pend && match) begin
            found     <= 1'b1;
            best_idx  <= pidx;
            best_mask <= rd_route.mask;
            best_hop  <= rd_route.hop;
            best_port <= rd_route.port;
          end
          if (!pend && (iss == count)) begin
            state <= B_RESULT;
          end
        end
        B_RESULT: begin
          if (out_free) begin
            res_status    <= found ? ST_HIT : ST_MISS;
            res_idx       <= found ? INDEX_W'(best_idx) : '0;
            res_hop       <= found ? best_hop : '0;
            res_port      <= found ? best_port : '0;
            state         <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/longest_prefix_route_lookup.sv]
`timescale 1ns / 1ps
// Top level of the longest-prefix IPv4 route lookup engine.
// Depends on lpm_pkg, lpm_front, lpm_back (and lpm_ram below it).
//
//  Channel  | Direction | tdata (low bit up)                          | tuser
//  ---------+-----------+---------------------------------------------+-----------------
//  s_axis   | in        | dest_addr, entry_prefix, entry_mask,        | operation
//           |           | entry_gateway, entry_port, zero pad         |
//  m_axis   | out       | route_index, gateway, out_port, zero pad    | status
//
// A load transfer's result is registered as the back end takes it from the queue.
// A lookup scans every stored route: the table sits in one RAM with a
// single read port, and the scan reads and compares one route per cycle.
// Reset clears the queue, the route count and the output valid; the table
// itself needs no clearing, since only entries below the route count are read.
// The two-entry queue keeps accepting input transfers, until it is full, while
// the back end scans or while a result waits in the output register for m_axis_tready.
module longest_prefix_route_lookup
  import lpm_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int PORT_COUNT  = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dest_addr[31:0], entry_prefix[63:32], entry_mask[95:64],
  // entry_gateway[127:96], entry_port[129:128], zero[135:130]
  input  logic [135:0] s_axis_tdata,
  // operation[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // route_index[9:0], gateway[41:10], out_port[43:42], zero[47:44]
  output logic [47:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);

  // Queue head handed from front to back.
  logic  item_valid;
  logic  item_ready;
  item_t item;

  // Accept, classify, saturate the port and queue each transfer.
  lpm_front #(
    .PORT_COUNT (PORT_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  // Append routes, scan for the longest matching mask, register the result.
  lpm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[bench/longest_prefix_route_lookup_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for longest_prefix_route_lookup: random and directed route
// loads and lookups, predicted in order and compared per field. Depends on lpm_pkg.
module longest_prefix_route_lookup_test;
  import lpm_pkg::*;

  localparam int TABLE_DEPTH    = 1024;
  localparam int PORT_COUNT     = 4;
  localparam int RANDOM_ITEMS   = 520;
  localparam int HOLD_CYCLES    = 400;
  // A lookup on a full table scans all TABLE_DEPTH routes.
  localparam int DRAIN_CYCLES   = 1100;
  localparam int WATCHDOG_LIMIT = 20000;

  // Pacing of both sides, carried along with each queued transfer.
  typedef enum int {
    PACE_FREE        = 0,
    PACE_SEND_GAPS   = 1,
    PACE_RECV_STALLS = 2,
    PACE_BOTH        = 3,
    PACE_PRESSURE    = 4
  } pace_t;

  typedef struct {
    op_t               op;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
    pace_t             pace;
  } request_t;

  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  hop;
    logic [PORT_W-1:0]  port;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  request_t route_requests[$];
  answer_t  pending_answers[$];
  pace_t    cur_pace = PACE_FREE;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       quiet_cycles = 0;
  int       error_count = 0;

  // Route table as the bench expects the block to hold it.
  logic [ADDR_W-1:0] known_prefix[TABLE_DEPTH];
  logic [ADDR_W-1:0] known_mask[TABLE_DEPTH];
  logic [ADDR_W-1:0] known_hop[TABLE_DEPTH];
  logic [PORT_W-1:0] known_port[TABLE_DEPTH];
  int                known_count = 0;

  // Routes queued so far, used to aim lookups at stored prefixes and to repeat earlier routes.
  logic [ADDR_W-1:0] plan_prefix[TABLE_DEPTH];
  logic [ADDR_W-1:0] plan_mask[TABLE_DEPTH];
  int                plan_count = 0;

  longest_prefix_route_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PORT_COUNT (PORT_COUNT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int gap_pct(pace_t p);
    case (p)
      PACE_SEND_GAPS: return 68;
      PACE_BOTH:      return 35;
      default:        return 0;
    endcase
  endfunction

  function automatic int stall_pct(pace_t p);
    case (p)
      PACE_RECV_STALLS: return 68;
      PACE_BOTH:        return 35;
      default:          return 0;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] mask_of_len(int len);
    if (len == 0) return '0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  // Apply one accepted transfer to the expected table and return its answer.
  function automatic answer_t apply_request(op_t op, logic [135:0] data);
    logic [ADDR_W-1:0] dest;
    logic [PORT_W-1:0] port;
    answer_t           ans;
    int                best;
    dest       = data[31:0];
    port       = data[129:128];
    ans.status = ST_MISS;
    ans.index  = '0;
    ans.hop    = '0;
    ans.port   = '0;
    if (op == OP_LOAD) begin
      if (known_count >= TABLE_DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        if (port >= PORT_COUNT) port = PORT_W'(PORT_COUNT - 1);
        known_prefix[known_count] = data[63:32];
        known_mask[known_count]   = data[95:64];
        known_hop[known_count]    = data[127:96];
        known_port[known_count]   = port;
        known_count++;
        ans.status = ST_LOADED;
      end
    end else begin
      best = -1;
      // Later entries win ties on the mask, hence >=.
      for (int i = 0; i < known_count; i++) begin
        if ((dest & known_mask[i]) == known_prefix[i] &&
            (best < 0 || known_mask[i] >= known_mask[best])) best = i;
      end
      if (best >= 0) begin
        ans.status = ST_HIT;
        ans.index  = best[INDEX_W-1:0];
        ans.hop    = known_hop[best];
        ans.port   = known_port[best];
      end
    end
    return ans;
  endfunction

  task automatic queue_load(logic [ADDR_W-1:0] prefix, logic [ADDR_W-1:0] mask,
                            logic [ADDR_W-1:0] hop, logic [PORT_W-1:0] port, pace_t pace);
    request_t r;
    r.op     = OP_LOAD;
    r.dest   = $urandom;
    r.prefix = prefix;
    r.mask   = mask;
    r.hop    = hop;
    r.port   = port;
    r.pace   = pace;
    route_requests.push_back(r);
    if (plan_count < TABLE_DEPTH) begin
      plan_prefix[plan_count] = prefix;
      plan_mask[plan_count]   = mask;
      plan_count++;
    end
  endtask

  task automatic queue_lookup(logic [ADDR_W-1:0] dest, pace_t pace);
    request_t r;
    r.op     = OP_LOOKUP;
    r.dest   = dest;
    r.prefix = $urandom;
    r.mask   = $urandom;
    r.hop    = $urandom;
    r.port   = PORT_W'($urandom_range(0, 3));
    r.pace   = pace;
    route_requests.push_back(r);
  endtask

  function automatic logic [ADDR_W-1:0] near_route(int k);
    return (plan_prefix[k] & plan_mask[k]) | ($urandom & ~plan_mask[k]);
  endfunction

  task automatic queue_random_load(pace_t pace);
    logic [ADDR_W-1:0] prefix, mask, hop;
    int                r, k;
    r = $urandom_range(0, 99);
    if (r < 10 && plan_count > 0) begin
      // Same prefix and mask as an earlier route: the newer one must win.
      k      = $urandom_range(0, plan_count - 1);
      prefix = plan_prefix[k];
      mask   = plan_mask[k];
    end else if (r < 16) begin
      // Host bits set outside the mask: the route never matches.
      mask   = mask_of_len($urandom_range(0, 31));
      prefix = $urandom;
      if ((prefix & ~mask) == '0) prefix = prefix | ~mask;
    end else if (r < 24) begin
      mask   = $urandom;
      prefix = $urandom & mask;
    end else begin
      mask   = mask_of_len(r < 34 ? $urandom_range(1, 7) : $urandom_range(8, 32));
      prefix = $urandom & mask;
    end
    r = $urandom_range(0, 99);
    hop = (r < 5) ? 32'h0 : (r < 10) ? 32'hFFFF_FFFF : $urandom;
    queue_load(prefix, mask, hop, PORT_W'($urandom_range(0, 3)), pace);
  endtask

  task automatic queue_random_lookup(pace_t pace);
    if (plan_count > 0 && $urandom_range(0, 99) < 70)
      queue_lookup(near_route($urandom_range(0, plan_count - 1)), pace);
    else
      queue_lookup($urandom, pace);
  endtask

  task automatic report_mismatch(string detail);
    error_count++;
    if (error_count <= 10) $display("MISMATCH at %0t: %s", $realtime, detail);
  endtask

  // Driver: present the head of the request queue, hold it until the transfer.
  always @(posedge clk) begin : driver
    request_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pending_answers.push_back(apply_request(op_t'(s_axis_tuser[0]), s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (route_requests.size() != 0 &&
            $urandom_range(0, 99) >= gap_pct(route_requests[0].pace)) begin
          nxt = route_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, nxt.port, nxt.hop, nxt.mask, nxt.prefix, nxt.dest};
          s_axis_tuser  <= nxt.op;
          cur_pace      <= nxt.pace;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once when the pressure stretch begins.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (cur_pace == PACE_PRESSURE && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each result transfer against the oldest expected answer.
  always @(posedge clk) begin : monitor
    answer_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("result with none expected: status %0d index %0d hop %h port %0d",
                                    m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[41:10],
                                    m_axis_tdata[43:42]));
        end else begin
          want = pending_answers.pop_front();
          if (m_axis_tuser != want.status || m_axis_tdata[9:0] != want.index ||
              m_axis_tdata[41:10] != want.hop || m_axis_tdata[43:42] != want.port)
            report_mismatch($sformatf({"expected status %0d index %0d hop %h port %0d, ",
                                       "got status %0d index %0d hop %h port %0d"},
                                      want.status, want.index, want.hop, want.port,
                                      m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[41:10],
                                      m_axis_tdata[43:42]));
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct(cur_pace));
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int    done_random;
    int    chunk;
    int    pace_idx;
    bit    pressure_done;
    pace_t pace;

    // Directed: empty table, equal masks, host bits, host routes, zero and
    // odd masks, extremes of hop and port.
    queue_lookup(32'hFFFF_FFFF, PACE_FREE);
    queue_load(32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 2'd0, PACE_FREE);
    queue_load(32'h0A01_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 2'd1, PACE_FREE);
    queue_load(32'h0A01_0000, 32'hFFFF_0000, 32'h0A0A_0A0A, 2'd2, PACE_FREE);
    queue_lookup(32'h0A01_FFFF, PACE_FREE);
    queue_lookup(32'h0A02_0001, PACE_FREE);
    queue_lookup(32'h0B00_0000, PACE_FREE);
    queue_load(32'h0A00_00FF, 32'hFFFF_FF00, 32'h5555_AAAA, 2'd3, PACE_FREE);
    queue_lookup(32'h0A00_00FF, PACE_FREE);
    queue_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 2'd3, PACE_FREE);
    queue_lookup(32'hFFFF_FFFF, PACE_FREE);
    queue_lookup(32'hFFFF_FFFE, PACE_FREE);
    queue_load(32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_5555, 2'd1, PACE_FREE);
    queue_lookup(32'h0000_0000, PACE_FREE);
    queue_load(32'h8000_0000, 32'h0000_0000, 32'hDEAD_0001, 2'd2, PACE_FREE);
    queue_lookup(32'h8000_0000, PACE_FREE);
    queue_load(32'hA0A0_A0A0, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 2'd0, PACE_FREE);
    queue_lookup(32'hA5A5_A5A5, PACE_FREE);
    queue_load(32'h0A00_0000, 32'hFF00_0000, 32'h7777_7777, 2'd3, PACE_FREE);
    queue_lookup(32'h0A7F_0000, PACE_FREE);

    // Random part in stretches of changing pace, one of them under pressure.
    done_random   = 0;
    pace_idx      = 0;
    pressure_done = 1'b0;
    while (done_random < RANDOM_ITEMS) begin
      chunk = $urandom_range(20, 60);
      pace  = pace_t'(pace_idx % 4);
      pace_idx++;
      if (!pressure_done && done_random >= RANDOM_ITEMS / 2) begin
        pace          = PACE_PRESSURE;
        chunk         = 16;
        pressure_done = 1'b1;
      end
      repeat (chunk) begin
        if ($urandom_range(0, 99) < 45) queue_random_load(pace);
        else queue_random_lookup(pace);
        done_random++;
      end
    end

    // Add a default route and four more, aim lookups at the newest routes, then add random lookups.
    pace = pace_t'(pace_idx % 4);
    queue_load(32'h0, 32'h0, $urandom, PORT_W'($urandom_range(0, 3)), pace);
    repeat (4) queue_random_load(pace);
    repeat (12) queue_lookup(near_route($urandom_range(plan_count - 5, plan_count - 1)), pace);
    repeat (12) queue_random_lookup(pace);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: every request sent, every answer seen, then watch for strays.
    do @(negedge clk);
    while (route_requests.size() != 0 || s_axis_tvalid || pending_answers.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
